/* src/sfs_pkg.sv */
// Shared widths, item codes and defaults for the sprite frame sequencer.
package sfs_pkg;

	localparam int MODE_W    = 2;
	localparam int ID_W      = 4;
	localparam int SLOT_W    = 5;
	localparam int DUR_W     = 16;
	localparam int CNT_W     = 6;
	localparam int EL_W      = 20;
	localparam int FRAME_W   = 5;
	localparam int ACC_W     = 25;
	localparam int ACC_SUM_W = ACC_W + 1;
	localparam int Q_FRAC    = 8;

	localparam int DEF_ANIM_SLOTS = 16;
	localparam int DEF_MAX_FRAMES = 32;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;

	typedef enum logic [MODE_W-1:0] {
		MODE_TICK = 2'd0,
		MODE_DUR  = 2'd1,
		MODE_HDR  = 2'd2,
		MODE_PLAY = 2'd3
	} mode_t;

	localparam logic [0:0] REG_REVERSE = 1'b0;

endpackage

/* src/sfs_item_if.sv */
// Input item and result channels of the sprite frame sequencer.
interface sfs_item_if import sfs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [MODE_W-1:0]  mode;
	logic [ID_W-1:0]    anim_id;
	logic [SLOT_W-1:0]  frame_slot;
	logic [DUR_W-1:0]   frame_time_ms;
	logic [CNT_W-1:0]   frame_count;
	logic               loop_flag;
	logic [EL_W-1:0]    elapsed_q8;

	modport source (output valid, mode, anim_id, frame_slot, frame_time_ms, frame_count,
		loop_flag, elapsed_q8, input ready);
	modport sink (input valid, mode, anim_id, frame_slot, frame_time_ms, frame_count,
		loop_flag, elapsed_q8, output ready);
endinterface

interface sfs_result_if import sfs_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [FRAME_W-1:0] frame_index;
	logic               active;
	logic               completed_once;
	logic               finished;

	modport source (output valid, frame_index, active, completed_once, finished,
		input ready);
	modport sink (input valid, frame_index, active, completed_once, finished,
		output ready);
endinterface

/* src/sprite_frame_sequencer_top.sv */
// Sprite frame sequencer: duration memory, slot tables and the frame stepping sequencer.
//
// Channels: items (sink) carries one command per transfer: tick, duration write,
// header write or play. results (source) returns one status transfer per item:
// frame index, active, completed_once and finished, as they stand after the item.
// The APB port holds reverse_mode at byte address 0; pready is always high.
//
// Sequencing: a write or play item goes from its transfer to the execute state and then
// loads the result register. A tick with an active animation steps frames after execute:
// each step reads one duration from the single-port duration memory into a register and
// compares and subtracts in the next cycle. A tick with no active animation goes from
// execute straight to the result state. One item is in work at a time; the result
// register lets the next item transfer in while a result still waits.
//
// Reset: all slots undefined, counts and loop flags zero, nothing playing, timer
// and completed flag clear, reverse_mode 0. Duration entries stay undefined until
// written. When results stalls, the finished result holds in its register; the next item
// is still taken, but the block waits in its result state until the register is free.
module sprite_frame_sequencer_top import sfs_pkg::*; #(
	parameter int ANIM_SLOTS = DEF_ANIM_SLOTS,
	parameter int MAX_FRAMES = DEF_MAX_FRAMES
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	sfs_item_if.sink              items,
	sfs_result_if.source          results
);

	localparam int SW    = (ANIM_SLOTS > 1) ? $clog2(ANIM_SLOTS) : 1;
	localparam int FW    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CW    = $clog2(MAX_FRAMES + 1);
	localparam int DEPTH = ANIM_SLOTS * MAX_FRAMES;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD,
		ST_CMP,
		ST_RES
	} state_t;

	state_t state_q;

	mode_t             mode_q;
	logic [ID_W-1:0]   id_q;
	logic [SLOT_W-1:0] slot_q;
	logic [DUR_W-1:0]  dur_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              lp_q;
	logic [EL_W-1:0]   el_q;

	logic [CW-1:0] count_q   [ANIM_SLOTS];
	logic          loop_q    [ANIM_SLOTS];
	logic          defined_q [ANIM_SLOTS];

	logic [SW-1:0]    cur_anim_q;
	logic             cur_valid_q;
	logic [FW-1:0]    cur_frame_q;
	logic [CW-1:0]    cur_count_q;
	logic             cur_loop_q;
	logic [ACC_W-1:0] acc_q;
	logic             done_q;
	logic             rev_q;

	logic               out_valid_q;
	logic [FRAME_W-1:0] out_frame_q;
	logic               out_active_q;
	logic               out_done_q;
	logic               out_fin_q;

	logic [DUR_W-1:0] dur_mem [DEPTH];
	logic [DUR_W-1:0] rdata_q;

	logic             accept;
	logic [SW-1:0]    id_idx;
	logic             id_ok;
	logic             slot_ok;
	logic [CW-1:0]    cnt_sat;
	logic             active;
	logic [FW-1:0]    last_frame;
	logic [FW-1:0]    clamp_frame;
	logic [ACC_SUM_W-1:0] acc_sum;
	logic [ACC_W-1:0] acc_add;
	logic [DUR_W-1:0] dur_eff;
	logic [ACC_W-1:0] d_q8;
	logic             step_go;
	logic [FW-1:0]    next_frame;
	logic             at_end;
	logic             play_go;
	logic [CW-1:0]    play_count;
	logic [FW-1:0]    play_frame;
	logic             finished;
	logic             res_load;
	logic             mem_we;
	logic [AW-1:0]    wr_addr;
	logic [AW-1:0]    rd_addr;

	assign accept = items.valid && items.ready;
	assign items.ready = (state_q == ST_IDLE);

	always_comb begin
		id_idx     = SW'(id_q);
		id_ok      = int'(id_q) < ANIM_SLOTS;
		slot_ok    = int'(slot_q) < MAX_FRAMES;
		cnt_sat    = (int'(cnt_q) > MAX_FRAMES) ? CW'(MAX_FRAMES) : CW'(cnt_q);
		active     = cur_valid_q && (cur_count_q != '0);
		last_frame = FW'(cur_count_q - CW'(1));
		clamp_frame = (CW'(cur_frame_q) >= cur_count_q) ? last_frame : cur_frame_q;
		acc_sum    = {1'b0, acc_q} + ACC_SUM_W'(el_q);
		acc_add    = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];
		dur_eff    = (rdata_q == '0) ? DUR_W'(1) : rdata_q;
		d_q8       = ACC_W'({dur_eff, {Q_FRAC{1'b0}}});
		step_go    = acc_q >= d_q8;
		at_end     = 1'b0;
		if (!rev_q) begin
			if ((CW'(cur_frame_q) + CW'(1)) >= cur_count_q) begin
				next_frame = cur_loop_q ? '0 : last_frame;
				at_end     = 1'b1;
			end else begin
				next_frame = cur_frame_q + FW'(1);
			end
		end else begin
			if (cur_frame_q == '0) begin
				next_frame = cur_loop_q ? last_frame : '0;
				at_end     = 1'b1;
			end else begin
				next_frame = cur_frame_q - FW'(1);
			end
		end
		play_count = count_q[id_idx];
		play_go    = id_ok && !(cur_valid_q && (cur_anim_q == id_idx) && !done_q)
			&& defined_q[id_idx];
		play_frame = (rev_q && (play_count != '0)) ? FW'(play_count - CW'(1)) : '0;
		finished   = active && !cur_loop_q && (cur_frame_q == last_frame);
		res_load   = (state_q == ST_RES) && (!out_valid_q || results.ready);
		mem_we     = (state_q == ST_EXEC) && (mode_q == MODE_DUR) && id_ok && slot_ok;
		wr_addr    = AW'(AW'(id_idx) * AW'(MAX_FRAMES)) + AW'(slot_q);
		rd_addr    = AW'(AW'(cur_anim_q) * AW'(MAX_FRAMES)) + AW'(cur_frame_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			dur_mem[wr_addr] <= dur_q;
		end
		if (state_q == ST_RD) begin
			rdata_q <= dur_mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(items.mode);
			id_q   <= items.anim_id;
			slot_q <= items.frame_slot;
			dur_q  <= items.frame_time_ms;
			cnt_q  <= items.frame_count;
			lp_q   <= items.loop_flag;
			el_q   <= items.elapsed_q8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rev_q <= 1'b0;
		end else if (psel && penable && pwrite && (paddr[APB_ADDR_W-1:2] == REG_REVERSE)) begin
			rev_q <= pwdata[0];
		end
	end

	assign pready = 1'b1;
	assign prdata = (paddr[APB_ADDR_W-1:2] == REG_REVERSE) ? APB_DATA_W'(rev_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			for (int i = 0; i < ANIM_SLOTS; i++) begin
				count_q[i]   <= '0;
				loop_q[i]    <= 1'b0;
				defined_q[i] <= 1'b0;
			end
			cur_anim_q   <= '0;
			cur_valid_q  <= 1'b0;
			cur_frame_q  <= '0;
			cur_count_q  <= '0;
			cur_loop_q   <= 1'b0;
			acc_q        <= '0;
			done_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_frame_q  <= '0;
			out_active_q <= 1'b0;
			out_done_q   <= 1'b0;
			out_fin_q    <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					state_q <= ((mode_q == MODE_TICK) && active) ? ST_RD : ST_RES;
					case (mode_q)
						MODE_TICK: begin
							if (active) begin
								cur_frame_q <= clamp_frame;
								acc_q       <= acc_add;
							end
						end
						MODE_DUR: begin
						end
						MODE_HDR: begin
							if (id_ok) begin
								count_q[id_idx]   <= cnt_sat;
								loop_q[id_idx]    <= lp_q;
								defined_q[id_idx] <= 1'b1;
								if (cur_anim_q == id_idx) begin
									cur_count_q <= cnt_sat;
									cur_loop_q  <= lp_q;
								end
							end
						end
						MODE_PLAY: begin
							if (play_go) begin
								cur_anim_q  <= id_idx;
								cur_valid_q <= 1'b1;
								cur_count_q <= play_count;
								cur_loop_q  <= loop_q[id_idx];
								cur_frame_q <= play_frame;
								acc_q       <= '0;
								done_q      <= 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
				ST_RD: begin
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (step_go) begin
						acc_q       <= acc_q - d_q8;
						cur_frame_q <= next_frame;
						if (at_end) begin
							done_q <= 1'b1;
						end
						state_q <= ST_RD;
					end else begin
						state_q <= ST_RES;
					end
				end
				ST_RES: begin
					if (res_load) begin
						out_frame_q  <= FRAME_W'(cur_frame_q);
						out_active_q <= active;
						out_done_q   <= done_q;
						out_fin_q    <= finished;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid          = out_valid_q;
	assign results.frame_index    = out_frame_q;
	assign results.active         = out_active_q;
	assign results.completed_once = out_done_q;
	assign results.finished       = out_fin_q;

	a_accept_starts_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_EXEC))
		else $error("item transfer did not start execution");

	a_step_frame_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RD) |-> (active && (CW'(cur_frame_q) < cur_count_q)))
		else $error("frame step outside the active animation");

	a_result_from_res: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_RES))
		else $error("result loaded outside the result state");

	a_timer_below_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP) && !step_go |=> (acc_q < d_q8) && (state_q == ST_RES))
		else $error("tick ended with a whole frame duration left");

endmodule

/* test/tb_top.sv */
// Self-checking testbench for the sprite frame sequencer: stimulus, status prediction, checks.
`timescale 1ns / 1ps

module tb_top;
	import sfs_pkg::*;

	localparam int ANIM_N          = DEF_ANIM_SLOTS;
	localparam int FRAME_N         = DEF_MAX_FRAMES;
	localparam int unsigned ACC_SAT = (1 << ACC_W) - 1;
	localparam int PHASES          = 6;
	localparam int ITEMS_PER_PHASE = 317;
	localparam int SETTLE_CYCLES   = 8;
	localparam int WATCHDOG_LIMIT  = 600000;

	typedef struct packed {
		mode_t             mode;
		logic [ID_W-1:0]   anim_id;
		logic [SLOT_W-1:0] frame_slot;
		logic [DUR_W-1:0]  frame_time_ms;
		logic [CNT_W-1:0]  frame_count;
		logic              loop_flag;
		logic [EL_W-1:0]   elapsed_q8;
		logic              drain;
	} seq_item_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_index;
		logic               active;
		logic               completed_once;
		logic               finished;
	} seq_status_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	sfs_item_if   item_ch ();
	sfs_result_if res_ch ();

	sprite_frame_sequencer_top i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.items   (item_ch),
		.results (res_ch)
	);

	// shadow of the sequencer
	bit [DUR_W-1:0]   dur_mem [ANIM_N*FRAME_N];
	bit [CNT_W-1:0]   cnt_mem [ANIM_N];
	bit               loop_mem [ANIM_N];
	bit               def_mem [ANIM_N];
	bit [ID_W-1:0]    cur_anim;
	bit               cur_valid;
	bit [FRAME_W-1:0] cur_frame;
	bit [ACC_W-1:0]   acc;
	bit               done;
	bit               rev_mode;

	bit          dur_written [ANIM_N*FRAME_N];
	bit          drain_next;
	seq_item_t   pending_q[$];
	seq_status_t status_due_q[$];
	seq_item_t   drive_item;
	seq_status_t want;
	seq_status_t got;

	int send_idle_pct;
	int recv_stall_pct;
	int n_pushed;
	int n_accepted;
	int n_results;
	int n_errors;
	int n_steps;
	int n_ends;
	int idle_cycles;

	int send_idle_tab [PHASES] = '{0, 55, 0, 22, 0, 22};
	int recv_stall_tab [PHASES] = '{0, 0, 55, 22, 0, 22};
	bit rev_tab [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic int unsigned frame_span_q8(int unsigned frame);
		int unsigned d;
		d = dur_mem[int'(cur_anim) * FRAME_N + frame];
		if (d == 0)
			d = 1;
		return d << Q_FRAC;
	endfunction

	function automatic seq_status_t advance_sequencer(seq_item_t it);
		int unsigned n;
		int unsigned a;
		int unsigned d;
		int unsigned cnt;
		seq_status_t st;
		case (it.mode)
			MODE_TICK: begin
				n = cur_valid ? cnt_mem[cur_anim] : 0;
				if (n != 0) begin
					if (cur_frame >= n)
						cur_frame = FRAME_W'(n - 1);
					a = acc + it.elapsed_q8;
					if (a > ACC_SAT)
						a = ACC_SAT;
					d = frame_span_q8(cur_frame);
					while (a >= d) begin
						a -= d;
						n_steps++;
						if (!rev_mode) begin
							if (cur_frame + 1 >= n) begin
								cur_frame = loop_mem[cur_anim] ? '0 : FRAME_W'(n - 1);
								done = 1'b1;
								n_ends++;
							end else begin
								cur_frame++;
							end
						end else begin
							if (cur_frame == 0) begin
								cur_frame = loop_mem[cur_anim] ? FRAME_W'(n - 1) : '0;
								done = 1'b1;
								n_ends++;
							end else begin
								cur_frame--;
							end
						end
						d = frame_span_q8(cur_frame);
					end
					acc = ACC_W'(a);
				end
			end
			MODE_DUR: begin
				dur_mem[int'(it.anim_id) * FRAME_N + int'(it.frame_slot)] = it.frame_time_ms;
			end
			MODE_HDR: begin
				cnt = it.frame_count;
				if (cnt > FRAME_N)
					cnt = FRAME_N;
				cnt_mem[it.anim_id] = CNT_W'(cnt);
				loop_mem[it.anim_id] = it.loop_flag;
				def_mem[it.anim_id] = 1'b1;
			end
			default: begin
				if (!(cur_valid && cur_anim == it.anim_id && !done) && def_mem[it.anim_id]) begin
					n = cnt_mem[it.anim_id];
					cur_anim = it.anim_id;
					cur_valid = 1'b1;
					cur_frame = (rev_mode && n > 0) ? FRAME_W'(n - 1) : '0;
					acc = '0;
					done = 1'b0;
				end
			end
		endcase
		n = cur_valid ? cnt_mem[cur_anim] : 0;
		st.frame_index = cur_frame;
		st.active = (n != 0);
		st.completed_once = done;
		st.finished = (n != 0) && !loop_mem[cur_anim] && (cur_frame == n - 1);
		return st;
	endfunction

	function automatic void flag_mismatch(string what, int unsigned exp_v, int unsigned act_v);
		n_errors++;
		if (n_errors <= 10)
			$display("mismatch at result %0d: %s expected %0d actual %0d",
				n_results, what, exp_v, act_v);
	endfunction

	function automatic int unsigned rand_duration();
		int r;
		r = $urandom_range(99);
		if (r < 60)
			return $urandom_range(15);
		else if (r < 85)
			return $urandom_range(63);
		else if (r < 95)
			return $urandom_range(1023);
		return $urandom_range(16'hFFFF);
	endfunction

	function automatic int unsigned rand_elapsed();
		int r;
		r = $urandom_range(99);
		if (r < 20)
			return $urandom_range(255);
		else if (r < 90)
			return $urandom_range(32 << Q_FRAC);
		else if (r < 97)
			return $urandom_range(1 << 14);
		return $urandom_range(20'hFFFFF);
	endfunction

	function automatic int unsigned rand_count();
		int r;
		r = $urandom_range(99);
		if (r < 75)
			return $urandom_range(1, 6);
		else if (r < 90)
			return $urandom_range(FRAME_N);
		return $urandom_range(63);
	endfunction

	function automatic seq_item_t rand_item();
		seq_item_t it;
		it.mode          = mode_t'($urandom_range(3));
		it.anim_id       = ID_W'($urandom);
		it.frame_slot    = SLOT_W'($urandom);
		it.frame_time_ms = DUR_W'($urandom);
		it.frame_count   = CNT_W'($urandom);
		it.loop_flag     = 1'($urandom);
		it.elapsed_q8    = EL_W'($urandom);
		it.drain         = 1'b0;
		return it;
	endfunction

	function automatic void push_item(seq_item_t it);
		if (it.mode == MODE_DUR)
			dur_written[int'(it.anim_id) * FRAME_N + int'(it.frame_slot)] = 1'b1;
		it.drain = drain_next || ($urandom_range(99) == 0);
		drain_next = 1'b0;
		pending_q.push_back(it);
		n_pushed++;
	endfunction

	function automatic void queue_tick(int unsigned el);
		seq_item_t it;
		it = rand_item();
		it.mode = MODE_TICK;
		it.elapsed_q8 = EL_W'(el);
		push_item(it);
	endfunction

	function automatic void queue_duration(int id, int frame, int unsigned dur);
		seq_item_t it;
		it = rand_item();
		it.mode = MODE_DUR;
		it.anim_id = ID_W'(id);
		it.frame_slot = SLOT_W'(frame);
		it.frame_time_ms = DUR_W'(dur);
		push_item(it);
	endfunction

	function automatic void queue_header_raw(int id, int unsigned cnt, bit lp);
		seq_item_t it;
		it = rand_item();
		it.mode = MODE_HDR;
		it.anim_id = ID_W'(id);
		it.frame_count = CNT_W'(cnt);
		it.loop_flag = lp;
		push_item(it);
	endfunction

	// fill every duration the new count can reach before the header lands
	function automatic void queue_header(int id, int unsigned cnt, bit lp);
		int span;
		span = (cnt > FRAME_N) ? FRAME_N : cnt;
		for (int f = 0; f < span; f++)
			if (!dur_written[id * FRAME_N + f])
				queue_duration(id, f, rand_duration());
		queue_header_raw(id, cnt, lp);
	endfunction

	function automatic void queue_play(int id);
		seq_item_t it;
		it = rand_item();
		it.mode = MODE_PLAY;
		it.anim_id = ID_W'(id);
		push_item(it);
	endfunction

	function automatic void queue_noise();
		case ($urandom_range(3))
			0: queue_tick(rand_elapsed());
			1: queue_duration($urandom_range(ANIM_N - 1), $urandom_range(FRAME_N - 1),
				rand_duration());
			2: queue_header($urandom_range(ANIM_N - 1), rand_count(), 1'($urandom));
			default: queue_play($urandom_range(ANIM_N - 1));
		endcase
	endfunction

	function automatic void queue_episode();
		int slot;
		slot = $urandom_range(ANIM_N - 1);
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 4))
				queue_duration(slot, $urandom_range(FRAME_N - 1), rand_duration());
		if ($urandom_range(9) < 7)
			queue_header(slot, rand_count(), 1'($urandom));
		queue_play(slot);
		repeat ($urandom_range(2, 14)) begin
			case ($urandom_range(19))
				0: queue_noise();
				1: queue_play(slot);
				2: queue_duration(slot, $urandom_range(FRAME_N - 1), rand_duration());
				default: queue_tick(rand_elapsed());
			endcase
		end
	endfunction

	function automatic void queue_directed();
		queue_tick(20'hFFFFF);
		queue_play(3);
		queue_header(0, 0, 1'b1);
		queue_play(0);
		queue_tick(20'h00100);
		queue_duration(1, 0, 0);
		queue_duration(1, 1, 16'hFFFF);
		queue_duration(1, 2, 5);
		queue_header(1, 3, 1'b0);
		queue_play(1);
		queue_tick(20'h00100);
		queue_tick(20'hFFFFF);
		queue_play(1);
		queue_header(1, 1, 1'b0);
		queue_tick(0);
		drain_next = 1'b1;
		queue_play(1);
		queue_header_raw(2, 63, 1'b0);
		queue_play(2);
		queue_header_raw(2, 0, 1'b0);
		queue_duration(15, 31, 16'hFFFF);
		queue_tick(20'h00400);
	endfunction

	task automatic write_reverse(bit rev);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= APB_ADDR_W'(4 * REG_REVERSE);
		pwdata <= APB_DATA_W'(rev);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		rev_mode = rev;
	endtask

	task automatic wait_drained();
		while (n_results < n_pushed)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (item_ch.valid && item_ch.ready) begin
				status_due_q.push_back(advance_sequencer(drive_item));
				n_accepted++;
			end
			if (!item_ch.valid || item_ch.ready) begin
				if (pending_q.size() != 0 && !(pending_q[0].drain && status_due_q.size() != 0)
					&& $urandom_range(99) >= send_idle_pct) begin
					drive_item = pending_q.pop_front();
					item_ch.valid <= 1'b1;
					item_ch.mode <= drive_item.mode;
					item_ch.anim_id <= drive_item.anim_id;
					item_ch.frame_slot <= drive_item.frame_slot;
					item_ch.frame_time_ms <= drive_item.frame_time_ms;
					item_ch.frame_count <= drive_item.frame_count;
					item_ch.loop_flag <= drive_item.loop_flag;
					item_ch.elapsed_q8 <= drive_item.elapsed_q8;
				end else begin
					item_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				n_results++;
				got.frame_index = res_ch.frame_index;
				got.active = res_ch.active;
				got.completed_once = res_ch.completed_once;
				got.finished = res_ch.finished;
				if (status_due_q.size() == 0) begin
					flag_mismatch("unexpected transfer, frame_index", 0, got.frame_index);
				end else begin
					want = status_due_q.pop_front();
					if (got.frame_index !== want.frame_index)
						flag_mismatch("frame_index", want.frame_index, got.frame_index);
					if (got.active !== want.active)
						flag_mismatch("active", want.active, got.active);
					if (got.completed_once !== want.completed_once)
						flag_mismatch("completed_once", want.completed_once, got.completed_once);
					if (got.finished !== want.finished)
						flag_mismatch("finished", want.finished, got.finished);
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transfer for %0d cycles", idle_cycles);
			$display("sprite_frame_sequencer_top regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_ch.valid = 1'b0;
		item_ch.mode = '0;
		item_ch.anim_id = '0;
		item_ch.frame_slot = '0;
		item_ch.frame_time_ms = '0;
		item_ch.frame_count = '0;
		item_ch.loop_flag = 1'b0;
		item_ch.elapsed_q8 = '0;
		res_ch.ready = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			send_idle_pct = send_idle_tab[ph];
			recv_stall_pct = recv_stall_tab[ph];
			write_reverse(rev_tab[ph]);
			if (ph == 0)
				queue_directed();
			while (n_pushed < (ph + 1) * ITEMS_PER_PHASE)
				queue_episode();
		end
		wait_drained();
		$display("ran %0d items and %0d status transfers across %0d idle/reverse phases",
			n_accepted, n_results, PHASES);
		$display("stepped %0d frames and reached %0d sequence ends", n_steps, n_ends);
		if (n_errors == 0 && status_due_q.size() == 0) begin
			$display("sprite_frame_sequencer_top regression: pass");
		end else begin
			$display("%0d mismatches, %0d results outstanding", n_errors, status_due_q.size());
			$display("sprite_frame_sequencer_top regression: fail");
		end
		$finish;
	end

endmodule

/* files.f */
src/sfs_pkg.sv
src/sfs_item_if.sv
src/sprite_frame_sequencer_top.sv
test/tb_top.sv
